// ----- rtl/pgat_pkg.sv -----
// Package: shared types, codes and constants for the game port axis timer.
`default_nettype none

package pgat_pkg;

    localparam int AXIS_COUNT = 4;
    localparam int POS_W      = 16;
    localparam int CNT_W      = 21;
    localparam int TPU_W      = 10;
    localparam int JC_W       = 2;
    localparam int BTN_A_W    = 4;
    localparam int BTN_B_W    = 2;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    // Duration pipeline: scale, divide by 65, scale, divide by 1000, multiply.
    localparam int LANE_LAT   = 5;
    localparam int STEP_W     = $clog2(LANE_LAT);

    localparam int A_W        = 23;
    localparam int Q1_W       = 17;
    localparam int B_W        = 21;
    localparam int Q2_W       = 11;
    localparam int P1_W       = 46;
    localparam int P2_W       = 42;
    localparam int DIV65_SH   = 29;
    localparam int DIV1000_SH = 30;

    localparam logic [A_W-1:0]  SCALE_100  = A_W'(100);
    localparam logic [P1_W-1:0] RECIP_65   = P1_W'(((64'd1 << DIV65_SH) + 64'd64) / 64'd65);
    localparam logic [B_W-1:0]  SCALE_11   = B_W'(11);
    localparam logic [P2_W-1:0] RECIP_1000 = P2_W'(((64'd1 << DIV1000_SH) + 64'd999) / 64'd1000);
    localparam logic [Q2_W-1:0] OFFSET_24  = Q2_W'(24);

    localparam logic [BYTE_W-1:0] BUSY_MASK = 8'h0f;
    localparam logic [BYTE_W-1:0] BTN_MASK  = 8'hf0;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_SPARE = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_JOY_COUNT = 1'b0,
        CFG_TICKS     = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic tick;
        logic set;
        logic load;
    } t_axis_ctl;

    function automatic logic [BYTE_W-1:0] port_byte(
        input logic [AXIS_COUNT-1:0] busy,
        input logic [JC_W-1:0]       jc,
        input logic [BTN_A_W-1:0]    btn_a,
        input logic [BTN_B_W-1:0]    btn_b
    );
        logic [BYTE_W-1:0] ret;
        ret = (BYTE_W'(busy) & BUSY_MASK) | BTN_MASK;
        if (jc != '0) begin
            ret = ret & ~{btn_a, 4'b0000};
        end
        if (jc[1]) begin
            ret = ret & ~{btn_b, 6'b000000};
        end
        return ret;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/pgat_lane.sv -----
// Duration lane: converts one axis position into a tick count over five stages.
`default_nettype none

module pgat_lane
    import pgat_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic signed [POS_W-1:0] i_pos,
    input  wire logic [TPU_W-1:0]        i_tpu,
    output logic [CNT_W-1:0]             o_dur
);

    logic [POS_W-1:0] u;
    logic [P1_W-1:0]  p1;
    logic [P2_W-1:0]  p2;
    logic [Q2_W-1:0]  q2_off;

    logic [A_W-1:0]   r_a;
    logic [Q1_W-1:0]  r_q1;
    logic [B_W-1:0]   r_b;
    logic [Q2_W-1:0]  r_q2;
    logic [CNT_W-1:0] r_dur;

    assign u      = {~i_pos[POS_W-1], i_pos[POS_W-2:0]};
    assign p1     = P1_W'(r_a) * RECIP_65;
    assign p2     = P2_W'(r_b) * RECIP_1000;
    assign q2_off = r_q2 + OFFSET_24;

    always_ff @(posedge i_clk) begin
        r_a   <= A_W'(u) * SCALE_100;
        r_q1  <= p1[DIV65_SH +: Q1_W];
        r_b   <= B_W'(r_q1) * SCALE_11;
        r_q2  <= p2[DIV1000_SH +: Q2_W];
        r_dur <= CNT_W'(q2_off) * CNT_W'(i_tpu);
    end

    assign o_dur = r_dur;

endmodule

`default_nettype wire

// ----- rtl/pgat_counter.sv -----
// Axis counter: one down counter and its busy bit.
`default_nettype none

module pgat_counter
    import pgat_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_axis_ctl        i_ctl,
    input  wire logic [CNT_W-1:0] i_dur,
    output logic                  o_busy,
    output logic                  o_busy_next
);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_busy;
    logic             n_busy;

    always_comb begin
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (i_ctl.tick && r_cnt != '0) begin
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
            end
        end
        if (i_ctl.set) begin
            n_busy = 1'b1;
        end
        if (i_ctl.load) begin
            n_cnt = i_dur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
        end
    end

    assign o_busy      = r_busy;
    assign o_busy_next = n_busy;

endmodule

`default_nettype wire

// ----- rtl/pc_game_port_axis_timer.sv -----
// Top level: game port axis timer with four duration lanes and axis counters.
//
//   channel   direction  handshake                 payload
//   input     in         i_valid / o_stall         i_opcode, i_joy_*, i_buttons_*
//   output    out        o_valid / i_stall         o_port_byte
//   config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A tick or read result is registered in the cycle after acceptance; another
// may be accepted every cycle while no write runs and the output is free. A write
// holds input over 5 lane stages (scale, /65, scale, /1000, multiply) and emit.
// Reset is synchronous; counters and busy bits clear, registers return to 1 and 1.
// The output register frees itself when taken, so a result may wait under stall
// while the next tick or read is accepted in the cycle it leaves.
`default_nettype none

module pc_game_port_axis_timer
    import pgat_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,

    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [1:0]              i_opcode,
    input  wire logic signed [POS_W-1:0] i_joy_a_x,
    input  wire logic signed [POS_W-1:0] i_joy_a_y,
    input  wire logic signed [POS_W-1:0] i_joy_b_x,
    input  wire logic signed [POS_W-1:0] i_joy_b_y,
    input  wire logic [BTN_A_W-1:0]      i_buttons_a,
    input  wire logic [BTN_B_W-1:0]      i_buttons_b,

    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [BYTE_W-1:0]            o_port_byte,

    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data
);

    t_state              r_state;
    t_state              n_state;
    logic [STEP_W-1:0]   r_step;
    logic [STEP_W-1:0]   n_step;
    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_out_byte;
    logic [JC_W-1:0]     r_joy_count;
    logic [TPU_W-1:0]    r_tpu;
    logic [BTN_A_W-1:0]  r_btn_a;
    logic [BTN_B_W-1:0]  r_btn_b;

    logic                accept;
    logic                out_free;
    logic                is_write;
    logic                tick;
    logic                commit;
    logic                out_load;
    logic [BYTE_W-1:0]   out_byte;

    logic signed [POS_W-1:0] pos [AXIS_COUNT];
    logic [CNT_W-1:0]        dur [AXIS_COUNT];
    t_axis_ctl               ctl [AXIS_COUNT];
    logic [AXIS_COUNT-1:0]   busy;
    logic [AXIS_COUNT-1:0]   busy_next;

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != ST_IDLE) || !out_free;
    assign accept   = i_valid && !o_stall;
    assign is_write = i_opcode == OP_WRITE;
    assign tick     = accept && i_opcode == OP_TICK;

    assign pos[0] = i_joy_a_x;
    assign pos[1] = i_joy_a_y;
    assign pos[2] = i_joy_b_x;
    assign pos[3] = i_joy_b_y;

    for (genvar g = 0; g < AXIS_COUNT; g++) begin : g_axis
        pgat_lane u_lane (
            .i_clk (i_clk),
            .i_pos (pos[g]),
            .i_tpu (r_tpu),
            .o_dur (dur[g])
        );

        assign ctl[g].tick = tick;
        assign ctl[g].set  = commit;
        assign ctl[g].load = commit && ((g < 2) ? (r_joy_count != '0) : r_joy_count[1]);

        pgat_counter u_counter (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl[g]),
            .i_dur       (dur[g]),
            .o_busy      (busy[g]),
            .o_busy_next (busy_next[g])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && is_write) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (r_step == STEP_W'(LANE_LAT - 1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        commit   = 1'b0;
        out_load = 1'b0;
        n_step   = '0;
        out_byte = port_byte(busy_next, r_joy_count, i_buttons_a, i_buttons_b);
        unique case (r_state)
            ST_IDLE: begin
                out_load = accept && !is_write;
            end
            ST_CONV: begin
                commit = r_step == STEP_W'(LANE_LAT - 1);
                n_step = r_step + STEP_W'(1);
            end
            ST_EMIT: begin
                out_load = out_free;
                out_byte = port_byte(busy, r_joy_count, r_btn_a, r_btn_b);
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_joy_count <= JC_W'(1);
            r_tpu       <= TPU_W'(1);
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_JOY_COUNT: r_joy_count <= i_cfg_data[JC_W-1:0];
                    CFG_TICKS:     r_tpu       <= i_cfg_data[TPU_W-1:0];
                    default:       r_tpu       <= r_tpu;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_byte <= out_byte;
        end
        if (accept && is_write) begin
            r_btn_a <= i_buttons_a;
            r_btn_b <= i_buttons_b;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_port_byte = r_out_byte;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ----- rtl/pgat_checker.sv -----
// Checker: port-level properties of the game port axis timer, bound to the top level.
`default_nettype none

module pgat_checker
    import pgat_pkg::*;
(
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_valid,
    input wire logic                    o_stall,
    input wire logic [1:0]              i_opcode,
    input wire logic                    o_valid,
    input wire logic                    i_stall,
    input wire logic [BYTE_W-1:0]       o_port_byte
);

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_port_byte))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_opcode == OP_TICK || i_opcode == OP_READ) |=> o_valid)
        else $error("tick or read request gave no result");

    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_opcode == OP_WRITE |=> o_stall)
        else $error("write request did not hold the input");

endmodule

bind pc_game_port_axis_timer pgat_checker u_pgat_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_opcode    (i_opcode),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_port_byte (o_port_byte)
);

`default_nettype wire
